// ----- rtl/core/bss_pkg.sv -----
`timescale 1ns / 1ps
// Package for the beat step sequencer: constants, register indexes, FSM states
// and the accent-level voice decode. No dependencies.
package bss_pkg;

   localparam int unsigned PERIOD_W      = 34;
   localparam int unsigned COUNTDOWN_W   = PERIOD_W + 2;
   localparam int unsigned SINCE_W       = 18;
   localparam int unsigned STEP_W        = 4;
   localparam int unsigned VOICE_W       = 8;
   localparam int unsigned MAX_BEATS     = 16;
   localparam int unsigned MAX_SUBSTEPS  = 8;
   localparam int unsigned TABLE_DEPTH   = 128;
   localparam int unsigned TABLE_AW      = 7;
   localparam int unsigned FRAC_W        = 16;
   // substep * period, Q16 dropped: quotient width of the serial divider
   localparam int unsigned DIV_W         = STEP_W + PERIOD_W - FRAC_W;
   localparam int unsigned DIV_CNT_W     = 5;
   localparam int unsigned CSR_IDX_W     = 3;
   localparam int unsigned CSR_DATA_W    = PERIOD_W;
   localparam int unsigned REQ_DATA_W    = 16;
   localparam int unsigned RSP_DATA_W    = 48;

   localparam logic [SINCE_W-1:0] SINCE_MAX = '1;

   localparam logic [VOICE_W-1:0] MASK_ACCENT = 8'h01;
   localparam logic [VOICE_W-1:0] MASK_NORMAL = 8'h02;

   typedef enum logic [1:0] {
      LVL_MUTE   = 2'd0,
      LVL_NORMAL = 2'd1,
      LVL_ACCENT = 2'd2,
      LVL_MUTE3  = 2'd3
   } level_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PERIOD        = 3'd0,
      CSR_BEATS_PER_BAR = 3'd1,
      CSR_BARS_IN_LOOP  = 3'd2,
      CSR_SILENT_RUN    = 3'd3,
      CSR_SILENT_EN     = 3'd4,
      CSR_COUNT_IN_EN   = 3'd5,
      CSR_ACCENTS       = 3'd6,
      CSR_GROOVE_STEPS  = 3'd7
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_DECIDE,
      ST_RESULT
   } state_type;

   function automatic logic [VOICE_W-1:0] level_mask(input logic [1:0] lvl);
      logic [VOICE_W-1:0] m;
      unique case (level_type'(lvl))
         LVL_ACCENT: m = MASK_ACCENT;
         LVL_NORMAL: m = MASK_NORMAL;
         default:    m = '0;
      endcase
      return m;
   endfunction

endpackage

// ----- rtl/core/beat_step_sequencer_unit.sv -----
`timescale 1ns / 1ps
// Beat step sequencer: Q16 beat countdown, count-in, bars, silent bars and a
// groove table in block RAM. Depends on bss_pkg.
// A tick request runs through multiply, the serial sub-step divider, a table
// read and the result load, which waits for the response register to be free.
// No new request is taken until the previous tick has loaded its result; a groove
// write request is taken only while idle and gives no result.
// Reset: synchronous, active high; counters cleared, registers take their
// defaults, groove entries read zero through per-entry valid bits (no sweep).
module beat_step_sequencer_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [6:0] entry_index, [14:7] entry_voices, [15] zero
   input  logic [bss_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [0] kind
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [0] strike, [8:1] voice_mask, [12:9] beat_index, [20:13] bar_index,
   // [21] silent_now, [22] in_count_in, [40:23] ticks_since_beat, [47:41] zero
   output logic [bss_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bss_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bss_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int unsigned CW = bss_pkg::COUNTDOWN_W;
   localparam int unsigned PW = bss_pkg::STEP_W + bss_pkg::PERIOD_W;
   localparam logic signed [CW-1:0] ONE_Q16 = CW'(65536);
   localparam logic signed [CW-1:0] NEG_ONE_Q16 = -ONE_Q16;

   // configuration
   logic [bss_pkg::PERIOD_W-1:0] period_ff;
   logic [4:0]                   bpb_ff;
   logic [7:0]                   bars_ff;
   logic [7:0]                   silent_run_ff;
   logic                         silent_en_ff;
   logic [31:0]                  accents_ff;
   logic [bss_pkg::STEP_W-1:0]   groove_steps_ff;

   // sequencer state
   logic signed [CW-1:0]         countdown_ff, countdown_in;
   logic [bss_pkg::SINCE_W-1:0]  since_ff, since_in;
   logic [4:0]                   beat_ff, beat_in;
   logic [7:0]                   bar_ff, bar_in;
   logic [7:0]                   scount_ff, scount_in;
   logic                         silent_ff, silent_in;
   logic                         counting_ff, counting_in;
   logic [4:0]                   cin_ff, cin_in;
   logic [bss_pkg::STEP_W-1:0]   active_ff, active_in;
   logic [bss_pkg::STEP_W-1:0]   substep_ff, substep_in;
   logic                         plain_ff, plain_in;

   bss_pkg::state_type           state_ff, state_in;

   // divider and step decision
   logic [bss_pkg::DIV_W-1:0]    quo_ff;
   logic [bss_pkg::STEP_W-1:0]   rem_ff;
   logic [bss_pkg::DIV_CNT_W-1:0] div_cnt_ff;
   logic                         hit_ff;
   logic                         use_tbl_ff;
   logic [bss_pkg::VOICE_W-1:0]  fixed_voices_ff;

   // groove table
   logic [bss_pkg::VOICE_W-1:0]  groove_mem [bss_pkg::TABLE_DEPTH];
   logic [bss_pkg::TABLE_DEPTH-1:0] tbl_valid_ff;
   logic [bss_pkg::VOICE_W-1:0]  rd_data_ff;
   logic                         rd_valid_ff;

   // result register
   logic                         rsp_valid_ff;
   logic [bss_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   logic                         req_accept, tick_accept, wr_accept;
   logic                         csr_accept, rsp_free, result_load;
   logic [bss_pkg::TABLE_AW-1:0] wr_addr;
   logic [bss_pkg::VOICE_W-1:0]  wr_voices;

   // register writes win over requests and only land between ticks
   assign req_tready  = (state_ff == bss_pkg::ST_IDLE) && !csr_valid;
   assign req_accept  = req_tvalid && req_tready;
   assign tick_accept = req_accept && !req_tuser;
   assign wr_accept   = req_accept && req_tuser;
   assign wr_addr     = req_tdata[6:0];
   assign wr_voices   = req_tdata[14:7];
   assign csr_ready   = (state_ff == bss_pkg::ST_IDLE);
   assign csr_accept  = csr_valid && csr_ready;
   assign rsp_free    = !rsp_valid_ff || rsp_tready;
   assign result_load = (state_ff == bss_pkg::ST_RESULT) && rsp_free;
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = rsp_data_ff;

   // ---------------- beat firing (evaluated on tick acceptance)
   logic                        fire;
   logic [5:0]                  beat_sum;
   logic [8:0]                  bar_sum;
   logic [7:0]                  scount_sum;
   logic [bss_pkg::STEP_W-1:0]  steps_sat;

   always_comb begin
      countdown_in = countdown_ff;
      since_in     = since_ff;
      beat_in      = beat_ff;
      bar_in       = bar_ff;
      scount_in    = scount_ff;
      silent_in    = silent_ff;
      counting_in  = counting_ff;
      cin_in       = cin_ff;
      beat_sum     = {1'b0, beat_ff} + 6'd1;
      bar_sum      = {1'b0, bar_ff} + 9'd1;
      scount_sum   = scount_ff + 8'd1;
      fire         = countdown_ff[CW-1] || (countdown_ff == '0);
      steps_sat    = (groove_steps_ff > bss_pkg::STEP_W'(bss_pkg::MAX_SUBSTEPS))
                     ? bss_pkg::STEP_W'(bss_pkg::MAX_SUBSTEPS) : groove_steps_ff;
      if (fire) begin
         countdown_in = countdown_ff + $signed({2'b00, period_ff});
         since_in     = '0;
         if (counting_ff) begin
            if (cin_ff >= bpb_ff) begin
               counting_in = 1'b0;
               beat_in     = 5'd1;
               bar_in      = '0;
               silent_in   = 1'b0;
               scount_in   = '0;
            end else begin
               cin_in  = cin_ff + 5'd1;
               beat_in = cin_ff + 5'd1;
            end
         end else if (beat_sum > {1'b0, bpb_ff}) begin
            beat_in = 5'd1;
            bar_in  = (bar_sum >= {1'b0, bars_ff}) ? 8'd0 : bar_sum[7:0];
            if (silent_en_ff) begin
               if (silent_ff) begin
                  if (scount_sum >= silent_run_ff) begin
                     silent_in = 1'b0;
                     scount_in = '0;
                  end else begin
                     scount_in = scount_sum;
                  end
               end else if (silent_run_ff != '0) begin
                  silent_in = 1'b1;
               end
            end
         end else begin
            beat_in = beat_sum[4:0];
         end
      end
      plain_in   = counting_in || (steps_sat == '0);
      active_in  = plain_in ? bss_pkg::STEP_W'(1) : steps_sat;
      substep_in = fire ? '0 : substep_ff;
      if (!fire) begin
         plain_in  = plain_ff;
         active_in = active_ff;
      end
   end

   // ---------------- step decision and voice source
   logic [4:0]                  beat_m1;
   logic                        beat_ok;
   logic [8:0]                  tbl_idx;
   logic [1:0]                  lvl;
   logic [bss_pkg::STEP_W:0]    rem_sh;
   logic                        q_bit;
   logic signed [CW-1:0]        cd_dec;
   logic [bss_pkg::VOICE_W-1:0] voices;
   logic                        strike;
   logic [PW-1:0]               prod;

   always_comb begin
      beat_m1 = beat_ff - 5'd1;
      beat_ok = (beat_ff != '0) && ({1'b0, beat_ff} <= 6'(bss_pkg::MAX_BEATS));
      tbl_idx = 9'(beat_m1[3:0]) * 9'(active_ff) + 9'(substep_ff);
      lvl     = accents_ff[{beat_m1[3:0], 1'b0} +: 2];
      rem_sh  = {rem_ff, quo_ff[bss_pkg::DIV_W-1]};
      q_bit   = (rem_sh >= {1'b0, active_ff});
      cd_dec  = countdown_ff - ONE_Q16;
      prod    = PW'(substep_ff) * PW'(period_ff);
      strike  = hit_ff && !silent_ff;
      voices  = '0;
      if (strike) begin
         voices = use_tbl_ff ? (rd_valid_ff ? rd_data_ff : '0) : fixed_voices_ff;
      end
   end

   // ---------------- control FSM
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bss_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bss_pkg::ST_IDLE:   if (tick_accept) state_in = bss_pkg::ST_MUL;
         bss_pkg::ST_MUL:    state_in = bss_pkg::ST_DIV;
         bss_pkg::ST_DIV:    if (div_cnt_ff == '0) state_in = bss_pkg::ST_DECIDE;
         bss_pkg::ST_DECIDE: state_in = bss_pkg::ST_RESULT;
         bss_pkg::ST_RESULT: if (rsp_free) state_in = bss_pkg::ST_IDLE;
         default:            state_in = bss_pkg::ST_IDLE;
      endcase
   end

   // ---------------- configuration and sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff       <= bss_pkg::PERIOD_W'(1572864000);
         bpb_ff          <= 5'd4;
         bars_ff         <= 8'd4;
         silent_run_ff   <= '0;
         silent_en_ff    <= 1'b0;
         accents_ff      <= 32'h5555_5556;
         groove_steps_ff <= '0;
         countdown_ff    <= '0;
         since_ff        <= '0;
         beat_ff         <= '0;
         bar_ff          <= '0;
         scount_ff       <= '0;
         silent_ff       <= 1'b0;
         counting_ff     <= 1'b1;
         cin_ff          <= '0;
         active_ff       <= bss_pkg::STEP_W'(1);
         substep_ff      <= '0;
         plain_ff        <= 1'b1;
         rsp_valid_ff    <= 1'b0;
         tbl_valid_ff    <= '0;
      end else begin
         if (tick_accept) begin
            countdown_ff <= countdown_in;
            since_ff     <= since_in;
            beat_ff      <= beat_in;
            bar_ff       <= bar_in;
            scount_ff    <= scount_in;
            silent_ff    <= silent_in;
            counting_ff  <= counting_in;
            cin_ff       <= cin_in;
            active_ff    <= active_in;
            substep_ff   <= substep_in;
            plain_ff     <= plain_in;
         end else if (csr_accept) begin
            unique case (bss_pkg::csr_idx_type'(csr_index))
               bss_pkg::CSR_PERIOD:        period_ff       <= csr_data;
               bss_pkg::CSR_BEATS_PER_BAR: bpb_ff          <= csr_data[4:0];
               bss_pkg::CSR_BARS_IN_LOOP:  bars_ff         <= csr_data[7:0];
               bss_pkg::CSR_SILENT_RUN:    silent_run_ff   <= csr_data[7:0];
               bss_pkg::CSR_SILENT_EN:     silent_en_ff    <= csr_data[0];
               bss_pkg::CSR_COUNT_IN_EN: begin
                  // count-in is only armed before the first tick
                  if (beat_ff == '0) begin
                     counting_ff <= csr_data[0];
                     cin_ff      <= '0;
                  end
               end
               bss_pkg::CSR_ACCENTS:       accents_ff      <= csr_data[31:0];
               bss_pkg::CSR_GROOVE_STEPS:  groove_steps_ff <= csr_data[3:0];
               default: ;
            endcase
         end
         if (wr_accept) begin
            tbl_valid_ff[wr_addr] <= 1'b1;
         end
         if (result_load) begin
            countdown_ff <= (cd_dec < NEG_ONE_Q16) ? NEG_ONE_Q16 : cd_dec;
            if (since_ff != bss_pkg::SINCE_MAX) begin
               since_ff <= since_ff + bss_pkg::SINCE_W'(1);
            end
            if (hit_ff) substep_ff <= substep_ff + bss_pkg::STEP_W'(1);
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------- datapath: multiply, serial divide, decide, result
   always_ff @(posedge clock) begin
      if (state_ff == bss_pkg::ST_MUL) begin
         quo_ff     <= prod[PW-1:bss_pkg::FRAC_W];
         rem_ff     <= '0;
         div_cnt_ff <= bss_pkg::DIV_CNT_W'(bss_pkg::DIV_W - 1);
      end else if (state_ff == bss_pkg::ST_DIV) begin
         quo_ff     <= {quo_ff[bss_pkg::DIV_W-2:0], q_bit};
         rem_ff     <= q_bit ? bss_pkg::STEP_W'(rem_sh - {1'b0, active_ff})
                             : rem_sh[bss_pkg::STEP_W-1:0];
         div_cnt_ff <= div_cnt_ff - bss_pkg::DIV_CNT_W'(1);
      end
      if (state_ff == bss_pkg::ST_DECIDE) begin
         hit_ff <= (substep_ff < active_ff)
                   && ({{(bss_pkg::DIV_W - bss_pkg::SINCE_W){1'b0}}, since_ff} >= quo_ff);
         use_tbl_ff <= 1'b0;
         fixed_voices_ff <= '0;
         if (beat_ok) begin
            if (counting_ff) begin
               fixed_voices_ff <= (beat_ff == 5'd1) ? bss_pkg::MASK_ACCENT
                                                    : bss_pkg::MASK_NORMAL;
            end else if (plain_ff) begin
               fixed_voices_ff <= bss_pkg::level_mask(lvl);
            end else begin
               use_tbl_ff <= (tbl_idx < 9'(bss_pkg::TABLE_DEPTH));
            end
         end
      end
      if (result_load) begin
         rsp_data_ff <= {7'b0, since_ff, counting_ff, silent_ff, bar_ff,
                         beat_m1[3:0], voices, strike};
      end
   end

   // groove table RAM, one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_accept) begin
         groove_mem[wr_addr] <= wr_voices;
      end
      if (state_ff == bss_pkg::ST_DECIDE) begin
         rd_data_ff  <= groove_mem[tbl_idx[bss_pkg::TABLE_AW-1:0]];
         rd_valid_ff <= tbl_valid_ff[tbl_idx[bss_pkg::TABLE_AW-1:0]];
      end
   end

`ifndef SYNTHESIS
   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(state_ff == bss_pkg::ST_RESULT))
      else $error("result appeared without a result load");

   a_substep_bound: assert property (@(posedge clock) disable iff (reset)
      substep_ff <= active_ff)
      else $error("sub-step index ran past active step count");

   a_countdown_floor: assert property (@(posedge clock) disable iff (reset)
      countdown_ff >= NEG_ONE_Q16)
      else $error("beat countdown below one-sample floor");

   a_write_marks_valid: assert property (@(posedge clock) disable iff (reset)
      wr_accept |=> tbl_valid_ff[$past(wr_addr)])
      else $error("groove write did not mark its entry valid");
`endif

endmodule

// ----- test/beat_step_sequencer_unit_checker.sv -----
`timescale 1ns / 1ps
// Checker for the beat step sequencer: follows the request, response and register
// channels, predicts every tick response and compares it. Depends on bss_pkg.
module beat_step_sequencer_unit_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [bss_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [bss_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [bss_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bss_pkg::CSR_DATA_W-1:0] csr_data,
   output int                             mismatch_count,
   output int                             results_waiting
);
   import bss_pkg::*;

   // response layout, lowest field last
   typedef struct packed {
      logic [6:0]         pad;
      logic [SINCE_W-1:0] since;
      logic               count_in;
      logic               silent;
      logic [7:0]         bar;
      logic [3:0]         beat;
      logic [VOICE_W-1:0] voices;
      logic               strike;
   } tick_result_t;

   tick_result_t    due_ticks[$];
   int              errors;

   // register copies
   longint unsigned period_q16;
   int unsigned     beats_in_bar, loop_bars, silent_len, accents, groove_cfg;
   bit              silent_on;

   // sequencer state
   longint          countdown;
   int unsigned     since_cnt, beat_pos, bar_pos, silent_cnt, count_pos;
   int unsigned     steps_now, substep_next;
   bit              in_silent, counting, metronome;
   logic [7:0]      groove_mem[TABLE_DEPTH];

   always @(posedge clock) begin : track
      tick_result_t    want, got;
      longint unsigned offset;
      int unsigned     steps, entry;
      logic [1:0]      lvl;
      if (reset) begin
         period_q16   = 64'd1572864000;
         beats_in_bar = 4;
         loop_bars    = 4;
         silent_len   = 0;
         silent_on    = 1'b0;
         accents      = 32'h5555_5556;
         groove_cfg   = 0;
         countdown    = 0;
         since_cnt    = 0;
         beat_pos     = 0;
         bar_pos      = 0;
         silent_cnt   = 0;
         count_pos    = 0;
         in_silent    = 1'b0;
         counting     = 1'b1;
         steps_now    = 1;
         substep_next = 0;
         metronome    = 1'b1;
         for (int i = 0; i < TABLE_DEPTH; i++) groove_mem[i] = '0;
         due_ticks.delete();
         errors = 0;
         mismatch_count  <= 0;
         results_waiting <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (due_ticks.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("[%0t] response with no tick request outstanding: %h",
                           $realtime, rsp_tdata);
            end else begin
               want = due_ticks.pop_front();
               if (got !== want) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("[%0t] tick mismatch, expected: strike=%0d voices=%h beat=%0d",
                              $realtime, want.strike, want.voices, want.beat,
                              " bar=%0d silent=%0d count_in=%0d since=%0d pad=%h",
                              want.bar, want.silent, want.count_in, want.since, want.pad);
                     $display("[%0t] tick mismatch, actual:   strike=%0d voices=%h beat=%0d",
                              $realtime, got.strike, got.voices, got.beat,
                              " bar=%0d silent=%0d count_in=%0d since=%0d pad=%h",
                              got.bar, got.silent, got.count_in, got.since, got.pad);
                  end
               end
            end
         end

         if (csr_valid && csr_ready) begin
            case (csr_idx_type'(csr_index))
               CSR_PERIOD:        period_q16   = 64'(csr_data);
               CSR_BEATS_PER_BAR: beats_in_bar = 32'(csr_data[4:0]);
               CSR_BARS_IN_LOOP:  loop_bars    = 32'(csr_data[7:0]);
               CSR_SILENT_RUN:    silent_len   = 32'(csr_data[7:0]);
               CSR_SILENT_EN:     silent_on    = csr_data[0];
               CSR_COUNT_IN_EN: begin
                  // only arms before the first tick
                  if (beat_pos == 0) begin
                     counting  = csr_data[0];
                     count_pos = 0;
                  end
               end
               CSR_ACCENTS:       accents      = csr_data[31:0];
               CSR_GROOVE_STEPS:  groove_cfg   = 32'(csr_data[3:0]);
               default: ;
            endcase
         end

         if (req_tvalid && req_tready) begin
            if (req_tuser) begin
               groove_mem[req_tdata[6:0]] = req_tdata[14:7];
            end else begin
               want = '0;
               if (countdown <= 0) begin
                  // beat: period added back so the fraction carries
                  countdown = countdown + longint'(period_q16);
                  since_cnt = 0;
                  if (counting) begin
                     if (count_pos >= beats_in_bar) begin
                        counting   = 1'b0;
                        beat_pos   = 1;
                        bar_pos    = 0;
                        in_silent  = 1'b0;
                        silent_cnt = 0;
                     end else begin
                        count_pos = count_pos + 1;
                        beat_pos  = count_pos;
                     end
                  end else begin
                     beat_pos = beat_pos + 1;
                     if (beat_pos > beats_in_bar) begin
                        beat_pos = 1;
                        bar_pos  = bar_pos + 1;
                        if (bar_pos >= loop_bars) bar_pos = 0;
                        if (silent_on) begin
                           if (in_silent) begin
                              silent_cnt = (silent_cnt + 1) & 32'hFF;
                              if (silent_cnt >= silent_len) begin
                                 in_silent  = 1'b0;
                                 silent_cnt = 0;
                              end
                           end else if (silent_len > 0) begin
                              in_silent = 1'b1;
                           end
                        end
                     end
                  end
                  steps        = (groove_cfg > MAX_SUBSTEPS) ? MAX_SUBSTEPS : groove_cfg;
                  metronome    = counting || (steps == 0);
                  steps_now    = metronome ? 1 : steps;
                  substep_next = 0;
               end

               if (substep_next < steps_now) begin
                  offset = (longint'(substep_next) * period_q16) /
                           (longint'(steps_now) << FRAC_W);
                  if (since_cnt >= offset) begin
                     if (!in_silent) begin
                        want.strike = 1'b1;
                        if (beat_pos >= 1 && beat_pos <= MAX_BEATS) begin
                           if (counting) begin
                              want.voices = (beat_pos == 1) ? MASK_ACCENT : MASK_NORMAL;
                           end else if (metronome) begin
                              lvl = 2'(accents >> (2 * (beat_pos - 1)));
                              case (level_type'(lvl))
                                 LVL_ACCENT: want.voices = MASK_ACCENT;
                                 LVL_NORMAL: want.voices = MASK_NORMAL;
                                 default:    want.voices = '0;
                              endcase
                           end else begin
                              entry = (beat_pos - 1) * steps_now + substep_next;
                              if (entry < TABLE_DEPTH) want.voices = groove_mem[entry];
                           end
                        end
                     end
                     substep_next = substep_next + 1;
                  end
               end

               want.since    = SINCE_W'(since_cnt);
               want.beat     = 4'(beat_pos - 1);
               want.bar      = 8'(bar_pos);
               want.silent   = in_silent;
               want.count_in = counting;

               countdown = countdown - (64'sd1 << FRAC_W);
               if (countdown < -(64'sd1 << FRAC_W)) countdown = -(64'sd1 << FRAC_W);
               if (since_cnt < SINCE_MAX) since_cnt = since_cnt + 1;
               due_ticks.push_back(want);
            end
         end

         mismatch_count  <= errors;
         results_waiting <= due_ticks.size();
      end
   end

endmodule

// ----- test/beat_step_sequencer_unit_tb.sv -----
`timescale 1ns / 1ps
// Top of the beat step sequencer testbench: clock, reset, request and register
// stimulus over several tempo and groove settings, watchdog and verdict.
// Depends on bss_pkg, beat_step_sequencer_unit and beat_step_sequencer_unit_checker.
module beat_step_sequencer_unit_tb;
   import bss_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int PHASES      = 16;
   localparam int PHASE_ITEMS = 30;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;
   logic                    req_tuser  = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_valid  = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index  = '0;
   logic [CSR_DATA_W-1:0]   csr_data   = '0;

   int mismatch_count;
   int results_waiting;
   int gap_pct     = 0;
   int stall_pct   = 0;
   int quiet_cycles = 0;

   beat_step_sequencer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   beat_step_sequencer_unit_checker u_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .mismatch_count  (mismatch_count),
      .results_waiting (results_waiting)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("[beat_step_sequencer_unit] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // leaves csr_valid high; the caller drops it after the last write
   task automatic write_reg(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic push_request(input logic is_write, input logic [6:0] idx,
                               input logic [7:0] voices);
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tuser  <= is_write;
      req_tdata  <= {1'b0, voices, idx};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // extra edge first: the checker count is registered behind the accepting edge
   task automatic wait_drained();
      @(posedge clock);
      while (results_waiting != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [CSR_DATA_W-1:0] p_period;
      logic [4:0]            p_beats;
      logic [7:0]            p_bars, p_srun;
      logic                  p_sen, p_cin;
      logic [31:0]           p_acc;
      logic [3:0]            p_steps;
      int                    r;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase % 4)
            0:       begin gap_pct = 0;  stall_pct = 0;  end
            1:       begin gap_pct = 57; stall_pct = 0;  end
            2:       begin gap_pct = 0;  stall_pct = 57; end
            default: begin gap_pct = 35; stall_pct = 35; end
         endcase

         if (phase > 0) begin
            wait_drained();
            // groove writes give no response; let the last one settle
            repeat (40) @(posedge clock);
         end

         p_acc = $urandom();
         p_cin = 1'($urandom_range(1));
         case (phase)
            0: begin
               // disarm then re-arm the count-in before the first tick
               write_reg(CSR_COUNT_IN_EN, '0);
               p_period = 34'd229376;   // 3.5 samples
               p_beats  = 5'd3;
               p_bars   = 8'd2;
               p_srun   = 8'd1;
               p_sen    = 1'b1;
               p_cin    = 1'b1;
               p_acc    = 32'h0000_00E4; // mute, normal, accent, mute3
               p_steps  = 4'd0;
            end
            1: begin
               // beat per tick, beats past the accent range, saturated steps
               p_period = '0;
               p_beats  = 5'd17;
               p_bars   = 8'd0;
               p_srun   = 8'd0;
               p_sen    = 1'b1;
               p_acc    = 32'hFFFF_FFFF;
               p_steps  = 4'd15;
            end
            2: begin
               p_period = 34'd65536;
               p_beats  = 5'd0;
               p_bars   = 8'd1;
               p_srun   = 8'd255;
               p_sen    = 1'b1;
               p_acc    = 32'h0000_0000;
               p_steps  = 4'd8;
            end
            3: begin
               // zero run with silence enabled ends the long silent run
               p_period = 34'd344064;
               p_beats  = 5'd4;
               p_bars   = 8'd255;
               p_srun   = 8'd0;
               p_sen    = 1'b1;
               p_steps  = 4'd3;
            end
            PHASES - 1: begin
               p_period = '1;
               p_beats  = 5'd4;
               p_bars   = 8'd4;
               p_srun   = 8'd0;
               p_sen    = 1'b1;
               p_steps  = 4'd2;
            end
            default: begin
               r = $urandom_range(19);
               if (r == 0)      p_period = '0;
               else if (r == 1) p_period = 34'd65536;
               else if (r == 2) p_period = CSR_DATA_W'($urandom_range(65535));
               else             p_period = CSR_DATA_W'($urandom_range(12 * 65536, 65536));
               r = $urandom_range(9);
               if (r == 0)      p_beats = 5'd0;
               else if (r == 1) p_beats = 5'd16;
               else if (r == 2) p_beats = 5'd31;
               else             p_beats = 5'($urandom_range(6, 1));
               r = $urandom_range(9);
               if (r == 0)      p_bars = 8'd0;
               else if (r == 1) p_bars = 8'd1;
               else if (r == 2) p_bars = 8'd255;
               else             p_bars = 8'($urandom_range(5, 2));
               p_srun  = 8'($urandom_range(3));
               p_sen   = ($urandom_range(9) < 7);
               p_steps = ($urandom_range(3) == 0) ? 4'd0 : 4'($urandom_range(15, 1));
            end
         endcase

         write_reg(CSR_PERIOD,        p_period);
         write_reg(CSR_BEATS_PER_BAR, CSR_DATA_W'(p_beats));
         write_reg(CSR_BARS_IN_LOOP,  CSR_DATA_W'(p_bars));
         write_reg(CSR_SILENT_RUN,    CSR_DATA_W'(p_srun));
         write_reg(CSR_SILENT_EN,     CSR_DATA_W'(p_sen));
         write_reg(CSR_COUNT_IN_EN,   CSR_DATA_W'(p_cin));
         write_reg(CSR_ACCENTS,       CSR_DATA_W'(p_acc));
         write_reg(CSR_GROOVE_STEPS,  CSR_DATA_W'(p_steps));
         csr_valid <= 1'b0;

         if (phase == 0) begin
            // table extremes, then count-in, a played bar and a silent bar
            push_request(1'b1, 7'd0,   8'hFF);
            push_request(1'b1, 7'd127, 8'h00);
            for (int n = 0; n < 23; n++)
               push_request(1'b0, 7'($urandom_range(127)), 8'($urandom_range(255)));
         end else begin
            for (int n = 0; n < PHASE_ITEMS; n++) begin
               if (n == PHASE_ITEMS / 2 && (phase == 2 || $urandom_range(3) == 0)) begin
                  req_tvalid <= 1'b0;
                  wait_drained();
               end
               if ($urandom_range(3) == 0)
                  push_request(1'b1, 7'($urandom_range(127)), 8'($urandom_range(255)));
               else
                  push_request(1'b0, 7'($urandom_range(127)), 8'($urandom_range(255)));
            end
         end
         req_tvalid <= 1'b0;
      end

      wait_drained();
      repeat (60) @(posedge clock);
      #1;
      if (mismatch_count == 0 && results_waiting == 0)
         $display("[beat_step_sequencer_unit] OK");
      else
         $display("[beat_step_sequencer_unit] ERROR");
      $finish;
   end

endmodule
